>>> rtl/core/ilsc_pkg.sv
// Shared types and constants for the idle/lock/suspend power policy controller.
`default_nettype none

package ilsc_pkg;

  localparam int TIME_BITS_DEF = 64;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int TMO_W     = 32;

  localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST = 32'd30000;
  localparam logic [CFG_W-1:0] LOCK_TIMEOUT_RST = 32'd60000;
  localparam logic [CFG_W-1:0] RETRY_DELAY_RST  = 32'd5000;

  localparam logic [TMO_W-1:0] TMO_NONE    = '1;
  localparam logic [TMO_W-1:0] TMO_INT_MAX = 32'h7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_TIMEOUT = 2'd0,
    CFG_LOCK_TIMEOUT = 2'd1,
    CFG_RETRY_DELAY  = 2'd2
  } ilsc_cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_TICK        = 3'd0,
    KIND_ACTIVITY    = 3'd1,
    KIND_LOCK        = 3'd2,
    KIND_UNLOCK      = 3'd3,
    KIND_SUSP_FAILED = 3'd4,
    KIND_UNAVAILABLE = 3'd5,
    KIND_RESUMED     = 3'd6,
    KIND_WAKE        = 3'd7
  } ilsc_kind_t;

  typedef enum logic [1:0] {
    MODE_ACTIVE  = 2'd0,
    MODE_LOCKED  = 2'd1,
    MODE_SUSPEND = 2'd2
  } ilsc_mode_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_LOCK    = 2'd1,
    ACT_SUSPEND = 2'd2
  } ilsc_action_t;

  typedef struct packed {
    logic [TMO_W-1:0] timeout_ms;
    ilsc_mode_t       mode;
    logic             wake_suppressed;
    logic             accepted;
    ilsc_action_t     action;
  } ilsc_result_t;

endpackage

`default_nettype wire

>>> rtl/core/ilsc_step.sv
// Per-event policy logic: next controller state and the result for one event.
`default_nettype none

module ilsc_step #(
  parameter int TIME_BITS = ilsc_pkg::TIME_BITS_DEF
) (
  input  wire ilsc_pkg::ilsc_kind_t     kind,
  input  wire logic [TIME_BITS-1:0]     now,
  input  wire logic                     desktop_shown,
  input  wire logic                     button_pressed,
  input  wire logic [ilsc_pkg::CFG_W-1:0] idle_timeout,
  input  wire logic [ilsc_pkg::CFG_W-1:0] lock_timeout,
  input  wire logic [ilsc_pkg::CFG_W-1:0] retry_delay,
  input  wire ilsc_pkg::ilsc_mode_t     mode,
  input  wire logic [TIME_BITS-1:0]     last_act,
  input  wire logic [TIME_BITS-1:0]     lock_time,
  input  wire logic [TIME_BITS-1:0]     retry_time,
  input  wire logic                     suspend_off,
  input  wire logic                     suppress_wake,
  output ilsc_pkg::ilsc_mode_t          mode_nxt,
  output logic [TIME_BITS-1:0]          last_act_nxt,
  output logic [TIME_BITS-1:0]          lock_time_nxt,
  output logic [TIME_BITS-1:0]          retry_time_nxt,
  output logic                          suspend_off_nxt,
  output logic                          suppress_wake_nxt,
  output ilsc_pkg::ilsc_result_t        result
);
  import ilsc_pkg::*;

  // two guard bits: base + span - now never overflows
  localparam int W = TIME_BITS + 2;
  localparam logic [W-1:0] TIME_MAX_W = {3'b000, {(TIME_BITS-1){1'b1}}};

  // base + span - now, with base a signed time and now non-negative
  function automatic logic signed [W-1:0] deadline_gap(input logic [TIME_BITS-1:0] base,
                                                       input logic [CFG_W-1:0] span,
                                                       input logic [TIME_BITS-1:0] t);
    logic signed [W-1:0] b;
    logic signed [W-1:0] s;
    logic signed [W-1:0] n;
    b = {{2{base[TIME_BITS-1]}}, base};
    s = {{(W-CFG_W){1'b0}}, span};
    n = {2'b00, t};
    return b + s - n;
  endfunction

  function automatic logic [TMO_W-1:0] clamp(input logic signed [W-1:0] d);
    logic [TMO_W-1:0] r;
    if (d <= 0) begin
      r = '0;
    end else if (d > $signed({{(W-TMO_W){1'b0}}, TMO_INT_MAX})) begin
      r = TMO_INT_MAX;
    end else begin
      r = d[TMO_W-1:0];
    end
    return r;
  endfunction

  logic                   idle_hit;
  logic                   lock_hit;
  logic                   retry_ok;
  logic [W-1:0]           retry_sum;
  logic [TIME_BITS-1:0]   retry_sat;
  logic [TMO_W-1:0]       rem_idle;
  logic [TMO_W-1:0]       rem_lock;
  logic [TMO_W-1:0]       rem_retry;
  ilsc_action_t           action;
  logic                   accepted;
  logic                   swallowed;
  logic [TMO_W-1:0]       timeout;

  // a deadline is reached exactly when base + span - now <= 0
  assign idle_hit = deadline_gap(last_act, idle_timeout, now) <= 0;
  assign lock_hit = deadline_gap(lock_time, lock_timeout, now) <= 0;
  assign retry_ok = retry_time[TIME_BITS-1] || ($signed(now) >= $signed(retry_time));

  assign retry_sum = {2'b00, now} + {{(W-CFG_W){1'b0}}, retry_delay};
  assign retry_sat = (retry_sum > TIME_MAX_W) ? TIME_MAX_W[TIME_BITS-1:0]
                                              : retry_sum[TIME_BITS-1:0];

  always_comb begin
    mode_nxt          = mode;
    last_act_nxt      = last_act;
    lock_time_nxt     = lock_time;
    retry_time_nxt    = retry_time;
    suspend_off_nxt   = suspend_off;
    suppress_wake_nxt = suppress_wake;
    action            = ACT_NONE;
    accepted          = 1'b0;
    swallowed         = 1'b0;
    unique case (kind)
      KIND_TICK: begin
        if (mode == MODE_ACTIVE && !desktop_shown && idle_hit) begin
          mode_nxt       = MODE_LOCKED;
          lock_time_nxt  = now;
          retry_time_nxt = '1;
          action         = ACT_LOCK;
        end else if (mode == MODE_LOCKED && !suspend_off && lock_hit && retry_ok) begin
          mode_nxt = MODE_SUSPEND;
          action   = ACT_SUSPEND;
        end
      end
      KIND_ACTIVITY: begin
        if (mode == MODE_ACTIVE) last_act_nxt = now;
      end
      KIND_LOCK: begin
        if (mode == MODE_ACTIVE) begin
          mode_nxt       = MODE_LOCKED;
          lock_time_nxt  = now;
          retry_time_nxt = '1;
          accepted       = 1'b1;
        end
      end
      KIND_UNLOCK: begin
        if (mode == MODE_LOCKED) begin
          mode_nxt          = MODE_ACTIVE;
          last_act_nxt      = now;
          lock_time_nxt     = '1;
          retry_time_nxt    = '1;
          suppress_wake_nxt = 1'b0;
          accepted          = 1'b1;
        end
      end
      KIND_SUSP_FAILED: begin
        mode_nxt       = MODE_LOCKED;
        retry_time_nxt = retry_sat;
      end
      KIND_UNAVAILABLE: begin
        mode_nxt        = MODE_LOCKED;
        retry_time_nxt  = '1;
        suspend_off_nxt = 1'b1;
      end
      KIND_RESUMED: begin
        mode_nxt          = MODE_LOCKED;
        lock_time_nxt     = now;
        retry_time_nxt    = '1;
        suspend_off_nxt   = 1'b0;
        suppress_wake_nxt = 1'b1;
      end
      KIND_WAKE: begin
        if (suppress_wake) begin
          if (!button_pressed) suppress_wake_nxt = 1'b0;
          swallowed = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // next deadline, measured against the updated state
  assign rem_idle  = clamp(deadline_gap(last_act_nxt, idle_timeout, now));
  assign rem_lock  = clamp(deadline_gap(lock_time_nxt, lock_timeout, now));
  assign rem_retry = clamp(deadline_gap(retry_time_nxt, '0, now));

  always_comb begin
    if (mode_nxt == MODE_ACTIVE && !desktop_shown) begin
      timeout = rem_idle;
    end else if (mode_nxt == MODE_LOCKED && !suspend_off_nxt) begin
      timeout = (rem_lock > rem_retry) ? rem_lock : rem_retry;
    end else begin
      timeout = TMO_NONE;
    end
  end

  assign result.action          = action;
  assign result.accepted        = accepted;
  assign result.wake_suppressed = swallowed;
  assign result.mode            = mode_nxt;
  assign result.timeout_ms      = timeout;

endmodule

`default_nettype wire

>>> rtl/core/idle_lock_suspend_controller_unit.sv
// Top level of the idle/lock/suspend power policy controller.
// Each event request yields exactly one result request. An event is taken into an
// input register, evaluated by the combinational policy logic in ilsc_step (the
// deadline subtractions and compares on TIME_BITS-wide times) and written to the
// result register; one event is accepted every clock while the result side keeps
// up. The policy state is updated in the same cycle an event moves into the result
// register, so back-to-back events see each other's effects. Write the timing
// registers only while no event is in flight.
`default_nettype none

module idle_lock_suspend_controller_unit #(
  parameter int TIME_BITS = ilsc_pkg::TIME_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ilsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ilsc_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [71:0]                    in_tdata,  // now_ms[62:0], desktop_shown,
                                                         // button_pressed, zero pad
  input  wire logic [2:0]                     in_tuser,  // kind
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [39:0]                         out_tdata  // action[1:0], accepted,
                                                         // wake_suppressed, mode[1:0],
                                                         // timeout_ms[31:0], zero pad
);
  import ilsc_pkg::*;

  logic [CFG_W-1:0]     idle_timeout_r;
  logic [CFG_W-1:0]     lock_timeout_r;
  logic [CFG_W-1:0]     retry_delay_r;

  logic                 s1_valid_r;
  ilsc_kind_t           s1_kind_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic                 s1_desk_r;
  logic                 s1_btn_r;

  ilsc_mode_t           mode_r, mode_nxt;
  logic [TIME_BITS-1:0] last_act_r, last_act_nxt;
  logic [TIME_BITS-1:0] lock_time_r, lock_time_nxt;
  logic [TIME_BITS-1:0] retry_time_r, retry_time_nxt;
  logic                 suspend_off_r, suspend_off_nxt;
  logic                 suppress_wake_r, suppress_wake_nxt;

  logic                 out_valid_r;
  ilsc_result_t         out_res_r;
  ilsc_result_t         step_res;
  logic                 s1_adv;
  logic                 in_take;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_timeout_r <= IDLE_TIMEOUT_RST;
      lock_timeout_r <= LOCK_TIMEOUT_RST;
      retry_delay_r  <= RETRY_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDLE_TIMEOUT: idle_timeout_r <= cfg_wdata;
        CFG_LOCK_TIMEOUT: lock_timeout_r <= cfg_wdata;
        CFG_RETRY_DELAY:  retry_delay_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register; only the low TIME_BITS-1 bits of the time are used
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_take) begin
      s1_kind_r <= ilsc_kind_t'(in_tuser);
      s1_now_r  <= {1'b0, in_tdata[TIME_BITS-2:0]};
      s1_desk_r <= in_tdata[63];
      s1_btn_r  <= in_tdata[64];
    end
  end

  ilsc_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .kind              (s1_kind_r),
    .now               (s1_now_r),
    .desktop_shown     (s1_desk_r),
    .button_pressed    (s1_btn_r),
    .idle_timeout      (idle_timeout_r),
    .lock_timeout      (lock_timeout_r),
    .retry_delay       (retry_delay_r),
    .mode              (mode_r),
    .last_act          (last_act_r),
    .lock_time         (lock_time_r),
    .retry_time        (retry_time_r),
    .suspend_off       (suspend_off_r),
    .suppress_wake     (suppress_wake_r),
    .mode_nxt          (mode_nxt),
    .last_act_nxt      (last_act_nxt),
    .lock_time_nxt     (lock_time_nxt),
    .retry_time_nxt    (retry_time_nxt),
    .suspend_off_nxt   (suspend_off_nxt),
    .suppress_wake_nxt (suppress_wake_nxt),
    .result            (step_res)
  );

  // policy state and result register advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_ACTIVE;
      last_act_r      <= '0;
      lock_time_r     <= '1;
      retry_time_r    <= '1;
      suspend_off_r   <= 1'b0;
      suppress_wake_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        mode_r          <= mode_nxt;
        last_act_r      <= last_act_nxt;
        lock_time_r     <= lock_time_nxt;
        retry_time_r    <= retry_time_nxt;
        suspend_off_r   <= suspend_off_nxt;
        suppress_wake_r <= suppress_wake_nxt;
      end
    end
    if (s1_adv && s1_valid_r) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.timeout_ms, out_res_r.mode,
                       out_res_r.wake_suppressed, out_res_r.accepted, out_res_r.action};

endmodule

`default_nettype wire
